>>> hdl/mva_pkg.sv
// Shared types and constants of the MIDI voice allocator.
package mva_pkg;

    localparam int CHANNELS_FIXED = 16;
    localparam int CH_W           = 4;
    localparam int OWNER_W        = 5;
    localparam int NOTE_W         = 7;
    localparam int BYTE7_W        = 7;
    localparam int DEPTH_W        = 14;
    localparam int BEND_W         = 15;
    localparam int PROD_W         = 30;
    localparam int BEND_SHIFT     = 13;

    localparam logic [OWNER_W-1:0] FREE_OWNER   = 5'h1F;
    localparam logic [BYTE7_W-1:0] RPN_RESET    = 7'h7F;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET  = 14'h0200;
    localparam logic [BEND_W-1:0]  BEND_CENTRE  = 15'h2000;
    localparam logic signed [PROD_W-1:0] BEND_ROUND = 30'sd4096;

    localparam logic [BYTE7_W-1:0] CC_DATA_ENTRY = 7'h06;
    localparam logic [BYTE7_W-1:0] CC_RPN_LSB    = 7'h64;
    localparam logic [BYTE7_W-1:0] CC_RPN_MSB    = 7'h65;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_BEND     = 4'hE;

    typedef enum logic [1:0] {
        CMD_STOP = 2'd0,
        CMD_PLAY = 2'd1,
        CMD_BEND = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [NOTE_W-1:0]  note;
    } voice_tag_t;

    localparam voice_tag_t VOICE_TAG_RESET = '{owner: FREE_OWNER, note: '0};

    typedef struct packed {
        logic [BYTE7_W-1:0]       program_no;
        logic [BYTE7_W-1:0]       rpn_lsb;
        logic [BYTE7_W-1:0]       rpn_msb;
        logic [DEPTH_W-1:0]       depth;
        logic signed [BEND_W-1:0] bend;
    } chan_entry_t;

    localparam chan_entry_t CHAN_RESET = '{
        program_no: '0,
        rpn_lsb:    RPN_RESET,
        rpn_msb:    RPN_RESET,
        depth:      DEPTH_RESET,
        bend:       '0
    };

endpackage

>>> hdl/mva_voice_mem.sv
// Voice state memory: owner, note and age per voice, with reset valid bits.
module mva_voice_mem #(
    parameter int VOICES   = 24,
    parameter int AGE_BITS = 32,
    localparam int IDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output mva_pkg::voice_tag_t   rd_tag,
    output logic [AGE_BITS-1:0]   rd_age,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  mva_pkg::voice_tag_t   wr_tag,
    input  logic [AGE_BITS-1:0]   wr_age
);
    import mva_pkg::*;

    voice_tag_t          tag_mem [VOICES];
    logic [AGE_BITS-1:0] age_mem [VOICES];
    logic [VOICES-1:0]   vld_reg;
    voice_tag_t          rd_tag_reg;
    logic [AGE_BITS-1:0] rd_age_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_addr] <= wr_tag;
            age_mem[wr_addr] <= wr_age;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (vld_reg[rd_addr]) begin
                rd_tag_reg <= tag_mem[rd_addr];
                rd_age_reg <= age_mem[rd_addr];
            end else begin
                rd_tag_reg <= VOICE_TAG_RESET;
                rd_age_reg <= '0;
            end
        end
    end

    assign rd_tag = rd_tag_reg;
    assign rd_age = rd_age_reg;

endmodule

>>> hdl/mva_chan_mem.sv
// Per-channel memory: program, RPN select, bend depth and scaled bend.
module mva_chan_mem (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   rd_en,
    input  logic [3:0]             rd_addr,
    output mva_pkg::chan_entry_t   rd_data,
    input  logic                   wr_en,
    input  logic [3:0]             wr_addr,
    input  mva_pkg::chan_entry_t   wr_data
);
    import mva_pkg::*;

    chan_entry_t                 mem [CHANNELS_FIXED];
    logic [CHANNELS_FIXED-1:0]   vld_reg;
    chan_entry_t                 rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : CHAN_RESET;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/midi_voice_allocator.sv
// MIDI voice allocator: sequencer, bend multiplier and output register.
// Sequence: note-on ends in ST_PLAY, note-off in ST_OFF and pitch bend in ST_BLAST, each
// waiting on output stalls; controller and program change end in ST_CHAN.
// Throughput: one item at a time; each note or bend item scans the voice memory once,
// one voice per cycle, except while a bend scan stalls on a busy output register.
// Reset: synchronous, active low; valid bits return both memories to their reset contents.
module midi_voice_allocator #(
    parameter int VOICES   = 24,
    parameter int CHANNELS = 16,
    parameter int AGE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // status[7:0], data1[14:8], data2[21:15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // voice[4:0], channel[8:5], program_res[15:9],
                                   // note[22:16], velocity[29:23], bend[44:30]
    output logic [1:0]  m_tuser,   // command[1:0]
    output logic        m_tlast
);
    import mva_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);
    localparam int CH_IDX_W = $clog2(CHANNELS);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CHAN  = 9'b000000010,
        ST_BMUL  = 9'b000000100,
        ST_BWR   = 9'b000001000,
        ST_SCAN  = 9'b000010000,
        ST_OFF   = 9'b000100000,
        ST_STOP  = 9'b001000000,
        ST_PLAY  = 9'b010000000,
        ST_BLAST = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_OFF,
        OP_ON,
        OP_CTRL,
        OP_PROG,
        OP_BEND
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next, op_dec;
    logic [CH_IDX_W-1:0] ch_reg, ch_next;
    logic [6:0] d1_reg, d1_next, d2_reg, d2_next;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                held_found_reg, held_found_next;
    logic [IDX_W-1:0]    held_idx_reg, held_idx_next;
    logic [AGE_BITS-1:0] held_age_reg, held_age_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [AGE_BITS-1:0] free_age_reg, free_age_next;
    logic [IDX_W-1:0]    min_idx_reg, min_idx_next;
    logic [AGE_BITS-1:0] min_age_reg, min_age_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [AGE_BITS-1:0] touch_reg, touch_next;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [BEND_W-1:0] bend_reg, bend_next;

    logic              m_valid_reg, m_valid_next;
    cmd_t              m_cmd_reg, m_cmd_next;
    logic [4:0]        m_voice_reg, m_voice_next;
    logic [3:0]        m_chan_reg, m_chan_next;
    logic [6:0]        m_prog_reg, m_prog_next;
    logic [6:0]        m_note_reg, m_note_next;
    logic [6:0]        m_vel_reg, m_vel_next;
    logic [BEND_W-1:0] m_bend_reg, m_bend_next;
    logic              m_last_reg, m_last_next;

    logic                v_rd_en;
    logic [IDX_W-1:0]    v_rd_addr;
    voice_tag_t          v_tag;
    logic [AGE_BITS-1:0] v_age;
    logic                v_wr_en;
    logic [IDX_W-1:0]    v_wr_addr;
    voice_tag_t          v_wr_tag;
    logic [AGE_BITS-1:0] v_wr_age;

    logic        c_rd_en;
    chan_entry_t c_rd;
    logic        c_wr_en;
    chan_entry_t c_wr;

    logic       accept;
    logic       out_free;
    logic       emit;
    cmd_t       e_cmd;
    logic [IDX_W-1:0] e_voice;
    logic [6:0] e_note, e_vel;
    logic [BEND_W-1:0] e_bend;
    logic       e_last;
    logic       owned, held, stall, is_last;
    logic [IDX_W-1:0] sel_idx;
    logic signed [BEND_W-1:0] bend_off, depth_s;
    logic signed [PROD_W-1:0] bend_sum;
    logic [AGE_BITS-1:0] touch_inc;

    mva_voice_mem #(
        .VOICES   (VOICES),
        .AGE_BITS (AGE_BITS)
    ) u_voice_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (v_rd_en),
        .rd_addr (v_rd_addr),
        .rd_tag  (v_tag),
        .rd_age  (v_age),
        .wr_en   (v_wr_en),
        .wr_addr (v_wr_addr),
        .wr_tag  (v_wr_tag),
        .wr_age  (v_wr_age)
    );

    mva_chan_mem u_chan_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (c_rd_en),
        .rd_addr (ch_next),
        .rd_data (c_rd),
        .wr_en   (c_wr_en),
        .wr_addr (ch_reg),
        .wr_data (c_wr)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        case (s_tdata[7:4])
            KIND_NOTE_OFF: op_dec = OP_OFF;
            KIND_NOTE_ON:  op_dec = (s_tdata[21:15] == 7'd0) ? OP_OFF : OP_ON;
            KIND_CTRL:     op_dec = OP_CTRL;
            KIND_PROGRAM:  op_dec = OP_PROG;
            KIND_BEND:     op_dec = OP_BEND;
            default:       op_dec = OP_NONE;
        endcase
    end

    assign bend_off  = $signed({1'b0, d2_reg, d1_reg} - BEND_CENTRE);
    assign depth_s   = $signed({1'b0, c_rd.depth});
    assign bend_sum  = prod_reg + BEND_ROUND;
    assign touch_inc = touch_reg + AGE_BITS'(1);

    assign owned   = (v_tag.owner == OWNER_W'(ch_reg));
    assign held    = owned && (v_tag.note == d1_reg);
    assign stall   = (op_reg == OP_BEND) && owned && pend_valid_reg && !out_free;
    assign is_last = (idx_reg == LAST_IDX);
    assign sel_idx = held_found_reg ? held_idx_reg :
                     (free_found_reg ? free_idx_reg : min_idx_reg);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        ch_next         = ch_reg;
        d1_next         = d1_reg;
        d2_next         = d2_reg;
        idx_next        = idx_reg;
        held_found_next = held_found_reg;
        held_idx_next   = held_idx_reg;
        held_age_next   = held_age_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        free_age_next   = free_age_reg;
        min_idx_next    = min_idx_reg;
        min_age_next    = min_age_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        touch_next      = touch_reg;
        prod_next       = prod_reg;
        bend_next       = bend_reg;

        v_rd_en   = 1'b0;
        v_rd_addr = '0;
        v_wr_en   = 1'b0;
        v_wr_addr = sel_idx;
        v_wr_tag  = '{owner: OWNER_W'(ch_reg), note: d1_reg};
        v_wr_age  = touch_inc;
        c_rd_en   = 1'b0;
        c_wr_en   = 1'b0;
        c_wr      = c_rd;

        emit    = 1'b0;
        e_cmd   = CMD_STOP;
        e_voice = sel_idx;
        e_note  = '0;
        e_vel   = '0;
        e_bend  = '0;
        e_last  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = op_dec;
                    ch_next    = s_tdata[3:0];
                    d1_next    = s_tdata[14:8];
                    d2_next    = s_tdata[21:15];
                    c_rd_en    = 1'b1;
                    state_next = ST_CHAN;
                end
            end
            ST_CHAN: begin
                bend_next       = c_rd.bend;
                idx_next        = '0;
                held_found_next = 1'b0;
                free_found_next = 1'b0;
                pend_valid_next = 1'b0;
                v_rd_addr       = '0;
                case (op_reg)
                    OP_CTRL: begin
                        if (d1_reg == CC_DATA_ENTRY) begin
                            if (c_rd.rpn_lsb == 7'd0 && c_rd.rpn_msb == 7'd0) begin
                                c_wr.depth = {d2_reg, 7'd0};
                            end
                        end else if (d1_reg == CC_RPN_LSB) begin
                            c_wr.rpn_lsb = d2_reg;
                        end else if (d1_reg == CC_RPN_MSB) begin
                            c_wr.rpn_msb = d2_reg;
                        end
                        c_wr_en    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_PROG: begin
                        c_wr.program_no = d1_reg;
                        c_wr_en         = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    OP_BEND: begin
                        state_next = ST_BMUL;
                    end
                    OP_ON, OP_OFF: begin
                        v_rd_en    = 1'b1;
                        state_next = ST_SCAN;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_BMUL: begin
                prod_next  = PROD_W'(bend_off) * PROD_W'(depth_s);
                state_next = ST_BWR;
            end
            ST_BWR: begin
                bend_next  = bend_sum[BEND_SHIFT+BEND_W-1:BEND_SHIFT];
                c_wr.bend  = bend_sum[BEND_SHIFT+BEND_W-1:BEND_SHIFT];
                c_wr_en    = 1'b1;
                v_rd_en    = 1'b1;
                v_rd_addr  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                v_rd_en   = 1'b1;
                v_rd_addr = (stall || is_last) ? idx_reg : idx_reg + IDX_W'(1);
                if (!stall) begin
                    if (held && !held_found_reg) begin
                        held_found_next = 1'b1;
                        held_idx_next   = idx_reg;
                        held_age_next   = v_age;
                    end
                    if (v_tag.owner == FREE_OWNER &&
                        (!free_found_reg || v_age < free_age_reg)) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                        free_age_next   = v_age;
                    end
                    if (idx_reg == '0 || v_age < min_age_reg) begin
                        min_idx_next = idx_reg;
                        min_age_next = v_age;
                    end
                    if (op_reg == OP_BEND && owned) begin
                        if (pend_valid_reg) begin
                            emit    = 1'b1;
                            e_cmd   = CMD_BEND;
                            e_voice = pend_idx_reg;
                            e_bend  = bend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                    end
                    if (is_last) begin
                        case (op_reg)
                            OP_OFF:  state_next = ST_OFF;
                            OP_ON:   state_next = ST_STOP;
                            default: state_next = ST_BLAST;
                        endcase
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_OFF: begin
                if (!held_found_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    emit       = 1'b1;
                    e_cmd      = CMD_STOP;
                    e_voice    = held_idx_reg;
                    e_last     = 1'b1;
                    v_wr_en    = 1'b1;
                    v_wr_addr  = held_idx_reg;
                    v_wr_tag   = '{owner: FREE_OWNER, note: d1_reg};
                    v_wr_age   = held_age_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_STOP: begin
                if (!held_found_reg) begin
                    state_next = ST_PLAY;
                end else if (out_free) begin
                    emit       = 1'b1;
                    e_cmd      = CMD_STOP;
                    e_voice    = held_idx_reg;
                    state_next = ST_PLAY;
                end
            end
            ST_PLAY: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_cmd      = CMD_PLAY;
                    e_note     = d1_reg;
                    e_vel      = d2_reg;
                    e_bend     = bend_reg;
                    e_last     = 1'b1;
                    v_wr_en    = 1'b1;
                    touch_next = touch_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_BLAST: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    emit       = 1'b1;
                    e_cmd      = CMD_BEND;
                    e_voice    = pend_idx_reg;
                    e_bend     = bend_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register; emit is only raised when the register is free
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_cmd_next   = m_cmd_reg;
        m_voice_next = m_voice_reg;
        m_chan_next  = m_chan_reg;
        m_prog_next  = m_prog_reg;
        m_note_next  = m_note_reg;
        m_vel_next   = m_vel_reg;
        m_bend_next  = m_bend_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_cmd_next   = e_cmd;
            m_voice_next = 5'(e_voice);
            m_chan_next  = 4'(ch_reg);
            m_prog_next  = c_rd.program_no;
            m_note_next  = e_note;
            m_vel_next   = e_vel;
            m_bend_next  = e_bend;
            m_last_next  = e_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            touch_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            touch_reg      <= touch_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        ch_reg         <= ch_next;
        d1_reg         <= d1_next;
        d2_reg         <= d2_next;
        idx_reg        <= idx_next;
        held_found_reg <= held_found_next;
        held_idx_reg   <= held_idx_next;
        held_age_reg   <= held_age_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        free_age_reg   <= free_age_next;
        min_idx_reg    <= min_idx_next;
        min_age_reg    <= min_age_next;
        pend_idx_reg   <= pend_idx_next;
        prod_reg       <= prod_next;
        bend_reg       <= bend_next;
        m_cmd_reg      <= m_cmd_next;
        m_voice_reg    <= m_voice_next;
        m_chan_reg     <= m_chan_next;
        m_prog_reg     <= m_prog_next;
        m_note_reg     <= m_note_next;
        m_vel_reg      <= m_vel_next;
        m_bend_reg     <= m_bend_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_cmd_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'd0, m_bend_reg, m_vel_reg, m_note_reg, m_prog_reg,
                       m_chan_reg, m_voice_reg};

endmodule
